// ----- sv/prc_pkg.sv -----
// Package for the polygon rectangle clipper.
// Holds the clip stage state type and the configuration register indexes.
// No dependencies.
`default_nettype none

package prc_pkg;

  localparam int NUM_STAGES = 4;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CROSS,
    S_VERT,
    S_CLOSE
  } cell_state_e;

endpackage

`default_nettype wire

// ----- sv/prc_if.sv -----
// Channel interfaces of the polygon rectangle clipper: vertex in, vertex out
// and configuration write. Depends on prc_pkg.
`default_nettype none

interface prc_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         final_vertex;
  modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
  modport mon    (input valid, ready, vertex_x, vertex_y, final_vertex);
endinterface

interface prc_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_last;
  logic                         clipped_empty;
  modport source (output valid, out_x, out_y, out_last, clipped_empty, input ready);
  modport sink   (input valid, out_x, out_y, out_last, clipped_empty, output ready);
  modport mon    (input valid, ready, out_x, out_y, out_last, clipped_empty);
endinterface

interface prc_cfg_if import prc_pkg::*; #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [COORD_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

`default_nettype wire

// ----- sv/polygon_rectangle_clipper_top.sv -----
// Top level of the polygon rectangle clipper: four clip stages in a chain
// plus the clip rectangle registers. Depends on prc_pkg, prc_if, prc_cell.
//
//   channel   direction  word
//   in_if     in         vertex_x, vertex_y, final_vertex
//   out_if    out        out_x, out_y, out_last, clipped_empty
//   cfg_if    in         index, data (clip rectangle edge)
//
// Each stage takes one vertex at a time and takes no new one until it is back
// in idle. A vertex that needs no crossing is handed out or dropped; a crossing
// costs a multiply step, the steps of the stage's restoring divider and a step
// to hand out the crossing, so one input word can yield up to three output
// words (entering crossing, the vertex, the closing word).
// The four stages overlap, each handing its output word to the next one.
// Reset clears the stage control and output state and loads the default rectangle.
// Both sides may stall freely; a full output register holds its word.
`default_nettype none

module polygon_rectangle_clipper_top import prc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  prc_in_if.sink      in_if,
  prc_out_if.source   out_if,
  prc_cfg_if.sink     cfg_if
);

  // Clip rectangle, one edge per stage: left, right, bottom, top.
  logic signed [COORD_BITS-1:0] bnd_q [NUM_STAGES];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q[0] <= COORD_BITS'(0);
      bnd_q[1] <= COORD_BITS'(1023);
      bnd_q[2] <= COORD_BITS'(0);
      bnd_q[3] <= COORD_BITS'(767);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_X_MIN: bnd_q[0] <= cfg_if.data;
        CFG_X_MAX: bnd_q[1] <= cfg_if.data;
        CFG_Y_MIN: bnd_q[2] <= cfg_if.data;
        CFG_Y_MAX: bnd_q[3] <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Links between stages; link 0 is the input, the last link the output.
  logic                         lv [NUM_STAGES+1];
  logic                         lr [NUM_STAGES+1];
  logic signed [COORD_BITS-1:0] lx [NUM_STAGES+1];
  logic signed [COORD_BITS-1:0] ly [NUM_STAGES+1];
  logic                         ll [NUM_STAGES+1];
  logic                         le [NUM_STAGES+1];

  assign lv[0]       = in_if.valid;
  assign in_if.ready = lr[0];
  assign lx[0]       = in_if.vertex_x;
  assign ly[0]       = in_if.vertex_y;
  assign ll[0]       = in_if.final_vertex;
  assign le[0]       = 1'b0;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    prc_cell #(
      .COORD_BITS (COORD_BITS),
      .IS_Y       (k >= 2),
      .IS_MAX     ((k % 2) == 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bnd_i       (bnd_q[k]),
      .in_valid_i  (lv[k]),
      .in_ready_o  (lr[k]),
      .in_x_i      (lx[k]),
      .in_y_i      (ly[k]),
      .in_last_i   (ll[k]),
      .in_empty_i  (le[k]),
      .out_valid_o (lv[k+1]),
      .out_ready_i (lr[k+1]),
      .out_x_o     (lx[k+1]),
      .out_y_o     (ly[k+1]),
      .out_last_o  (ll[k+1]),
      .out_empty_o (le[k+1])
    );
  end

  assign out_if.valid         = lv[NUM_STAGES];
  assign lr[NUM_STAGES]       = out_if.ready;
  assign out_if.out_x         = lx[NUM_STAGES];
  assign out_if.out_y         = ly[NUM_STAGES];
  assign out_if.out_last      = ll[NUM_STAGES];
  assign out_if.clipped_empty = le[NUM_STAGES];

endmodule

`default_nettype wire

// ----- sv/prc_cell.sv -----
// One clip stage of the polygon rectangle clipper: clips against one boundary.
// Crossings use a registered multiply and a restoring divider. Depends on prc_pkg.
`default_nettype none

module prc_cell import prc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter bit IS_Y       = 1'b0,
  parameter bit IS_MAX     = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COORD_BITS-1:0] bnd_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] in_x_i,
  input  logic signed [COORD_BITS-1:0] in_y_i,
  input  logic                         in_last_i,
  input  logic                         in_empty_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_last_o,
  output logic                         out_empty_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = $clog2(DW);

  cell_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic                         seen_q, has_out_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic                         cur_last_q, cur_empty_q, vert_q;
  logic [DW-1:0]                m1_q, m2_q, den_q, rem_q, quo_q;
  logic                         neg_q;
  logic signed [COORD_BITS-1:0] base_q, bnd_q;
  logic [CW-1:0]                cnt_q;
  logic                         ovalid_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q;
  logic                         olast_q, oempty_q;

  // Inside tests and crossing operands for the arriving vertex.
  logic signed [COORD_BITS-1:0] a_cur, o_cur, a_prv, o_prv, ai, oi, ao, oo;
  logic                         cin, pin;
  logic [DW-1:0]                d1, d2, d3, m1, m2, m3;

  always_comb begin
    a_cur = IS_Y ? in_y_i : in_x_i;
    o_cur = IS_Y ? in_x_i : in_y_i;
    a_prv = IS_Y ? prev_y_q : prev_x_q;
    o_prv = IS_Y ? prev_x_q : prev_y_q;
    cin   = IS_MAX ? (a_cur <= bnd_i) : (a_cur >= bnd_i);
    pin   = IS_MAX ? (a_prv <= bnd_i) : (a_prv >= bnd_i);
    ai    = cin ? a_cur : a_prv;
    oi    = cin ? o_cur : o_prv;
    ao    = cin ? a_prv : a_cur;
    oo    = cin ? o_prv : o_cur;
    d1    = DW'(bnd_i) - DW'(ai);
    d2    = DW'(oo) - DW'(oi);
    d3    = DW'(ao) - DW'(ai);
    m1    = d1[DW-1] ? (~d1 + 1'b1) : d1;
    m2    = d2[DW-1] ? (~d2 + 1'b1) : d2;
    m3    = d3[DW-1] ? (~d3 + 1'b1) : d3;
  end

  // Divider step and crossing result.
  logic [DW:0]                  r2, r2s;
  logic                         ge;
  logic [DW:0]                  sq, csum;
  logic signed [COORD_BITS-1:0] cross_o;

  always_comb begin
    r2      = {rem_q, quo_q[DW-1]};
    ge      = r2 >= {1'b0, den_q};
    r2s     = r2 - {1'b0, den_q};
    sq      = neg_q ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};
    csum    = (DW+1)'(base_q) + sq;
    cross_o = csum[COORD_BITS-1:0];
  end

  // Next state and output word selection.
  logic                         accept, slot_free, push;
  logic signed [COORD_BITS-1:0] px, py;
  logic                         plast, pempty;

  always_comb begin
    state_d   = state_q;
    slot_free = !ovalid_q || out_ready_i;
    accept    = 1'b0;
    push      = 1'b0;
    px        = cur_x_q;
    py        = cur_y_q;
    plast     = 1'b0;
    pempty    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        accept = in_valid_i;
        if (in_valid_i) begin
          if (in_empty_i) begin
            state_d = S_CLOSE;
          end else if (seen_q && (pin != cin)) begin
            state_d = S_MUL;
          end else if (seen_q && cin) begin
            state_d = S_VERT;
          end else if (in_last_i) begin
            state_d = S_CLOSE;
          end
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_CROSS;
        end
      end
      S_CROSS: begin
        px = IS_Y ? cross_o : bnd_q;
        py = IS_Y ? bnd_q : cross_o;
        if (slot_free) begin
          push = 1'b1;
          if (vert_q) begin
            state_d = S_VERT;
          end else if (cur_last_q) begin
            state_d = S_CLOSE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_VERT: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = cur_last_q ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        plast = 1'b1;
        if (cur_empty_q || !has_out_q) begin
          px     = '0;
          py     = '0;
          pempty = 1'b1;
        end else begin
          px = first_x_q;
          py = first_y_q;
        end
        if (slot_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stage state that reset and the closing word clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      seen_q    <= 1'b0;
      has_out_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      if (accept && !in_empty_i) begin
        prev_x_q <= in_x_i;
        prev_y_q <= in_y_i;
        seen_q   <= 1'b1;
      end
      if (push && state_q != S_CLOSE && !has_out_q) begin
        first_x_q <= px;
        first_y_q <= py;
        has_out_q <= 1'b1;
      end
      if (push && state_q == S_CLOSE) begin
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        first_x_q <= '0;
        first_y_q <= '0;
        seen_q    <= 1'b0;
        has_out_q <= 1'b0;
      end
      if (push) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload and arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q     <= in_x_i;
      cur_y_q     <= in_y_i;
      cur_last_q  <= in_last_i;
      cur_empty_q <= in_empty_i;
      vert_q      <= seen_q && cin;
      m1_q        <= m1;
      m2_q        <= m2;
      den_q       <= m3;
      neg_q       <= d1[DW-1] ^ d2[DW-1] ^ d3[DW-1];
      base_q      <= oi;
      bnd_q       <= bnd_i;
    end
    if (state_q == S_MUL) begin
      {rem_q, quo_q} <= PW'(m1_q) * PW'(m2_q);
      cnt_q          <= CW'(DW - 1);
    end
    if (state_q == S_DIV) begin
      rem_q <= ge ? r2s[DW-1:0] : r2[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
    if (push) begin
      ox_q     <= px;
      oy_q     <= py;
      olast_q  <= plast;
      oempty_q <= pempty;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_last_o  = olast_q;
  assign out_empty_o = oempty_q;

endmodule

`default_nettype wire

// ----- sv/prc_checker.sv -----
// Port checker for the polygon rectangle clipper and its bind.
// Depends on prc_if and polygon_rectangle_clipper_top.
`default_nettype none

module prc_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] out_x_i,
  input logic [COORD_BITS-1:0] out_y_i,
  input logic                  out_last_i,
  input logic                  out_empty_i,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_i
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i)
      && $stable(out_y_i) && $stable(out_last_i) && $stable(out_empty_i))
    else $error("output word changed while stalled");

  // An empty result closes the polygon and carries zero coordinates.
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |->
      out_last_i && out_x_i == '0 && out_y_i == '0)
    else $error("empty result malformed");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid after reset");

  // The rectangle registers take a write in any cycle.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind polygon_rectangle_clipper_top prc_checker #(
  .COORD_BITS (COORD_BITS)
) u_prc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_x_i     (out_if.out_x),
  .out_y_i     (out_if.out_y),
  .out_last_i  (out_if.out_last),
  .out_empty_i (out_if.clipped_empty),
  .cfg_valid_i (cfg_if.valid),
  .cfg_ready_i (cfg_if.ready)
);

`default_nettype wire
